// ----- rtl/core/cpmf_pkg.sv -----
// shared types and constants of the coap payload marker finder
package cpmf_pkg;

    localparam int unsigned MAX_MESSAGE_BYTES_DEF = 65535;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned PHASE_W = 3;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_HEADER    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DELTA_ONE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DELTA_TWO = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_ONE   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEN_HI    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LEN_LO    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_VALUE     = 3'd6;

    // result status codes
    localparam logic [1:0] ST_MARKER = 2'd0;
    localparam logic [1:0] ST_END    = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [7:0] MARKER_BYTE = 8'hFF;
    localparam logic [3:0] NIB_EXT_ONE = 4'd13;
    localparam logic [3:0] NIB_EXT_TWO = 4'd14;
    localparam logic [3:0] NIB_RESERVED = 4'd15;
    localparam logic [COUNT_W-1:0] LEN_ONE_BIAS = 17'd13;
    localparam logic [COUNT_W-1:0] LEN_TWO_BIAS = 17'd269;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cpmf_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] position;
    } cpmf_result_t;

endpackage

// ----- rtl/core/cpmf_in_stage.sv -----
// input register stage with upstream handshake
module cpmf_in_stage
    import cpmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    input  cpmf_item_t s_item,
    input  logic       advance,
    output logic       item_valid,
    output cpmf_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    cpmf_item_t item_reg;

    assign s_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/cpmf_parser.sv -----
// option header walker: parse state and per-byte step logic
module cpmf_parser
    import cpmf_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  cpmf_item_t   item,
    input  logic         step_en,
    output logic         emit,
    output cpmf_result_t result
);

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_MESSAGE_BYTES);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] value_rem_reg, value_rem_next;
    logic [3:0]         held_nib_reg, held_nib_next;
    logic [7:0]         len_hi_reg, len_hi_next;
    logic               decided_reg, decided_next;

    logic [3:0]         bl_nib;
    logic [PHASE_W-1:0] bl_phase;
    logic [COUNT_W-1:0] bl_value;
    logic [COUNT_W-1:0] len_one_value;
    logic [COUNT_W-1:0] len_two_value;
    logic [COUNT_W-1:0] value_dec;
    logic [7:0]         b;

    assign b = item.data_byte;

    // length nibble decode shared by header and last delta byte
    assign bl_nib = (phase_reg == PH_HEADER) ? b[3:0] : held_nib_reg;

    always_comb
    begin
        bl_value = '0;
        if (bl_nib == NIB_EXT_ONE)
        begin
            bl_phase = PH_LEN_ONE;
        end
        else if (bl_nib == NIB_EXT_TWO)
        begin
            bl_phase = PH_LEN_HI;
        end
        else
        begin
            bl_value = {{(COUNT_W-4){1'b0}}, bl_nib};
            bl_phase = (bl_nib == 4'd0) ? PH_HEADER : PH_VALUE;
        end
    end

    assign len_one_value = {{(COUNT_W-8){1'b0}}, b} + LEN_ONE_BIAS;
    assign len_two_value = {{(COUNT_W-16){1'b0}}, len_hi_reg, b} + LEN_TWO_BIAS;
    assign value_dec     = value_rem_reg - COUNT_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        value_rem_next  = value_rem_reg;
        held_nib_next   = held_nib_reg;
        len_hi_next     = len_hi_reg;
        decided_next    = decided_reg;
        emit            = 1'b0;
        result.status   = ST_MARKER;
        result.position = '0;

        if (decided_reg)
        begin
            // waiting for the final byte to rearm
            if (item.last_byte)
            begin
                phase_next      = PH_HEADER;
                byte_count_next = '0;
                value_rem_next  = '0;
                held_nib_next   = '0;
                len_hi_next     = '0;
                decided_next    = 1'b0;
            end
        end
        else
        begin
            byte_count_next = byte_count_reg + COUNT_W'(1);
            if (byte_count_reg >= MAX_COUNT)
            begin
                emit          = 1'b1;
                result.status = ST_ERROR;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (b == MARKER_BYTE)
                        begin
                            emit            = 1'b1;
                            result.status   = ST_MARKER;
                            result.position = byte_count_reg[15:0];
                        end
                        else
                        begin
                            held_nib_next = b[3:0];
                            if (b[7:4] == NIB_RESERVED || b[3:0] == NIB_RESERVED)
                            begin
                                emit          = 1'b1;
                                result.status = ST_ERROR;
                            end
                            else if (b[7:4] == NIB_EXT_ONE)
                            begin
                                phase_next = PH_DELTA_ONE;
                            end
                            else if (b[7:4] == NIB_EXT_TWO)
                            begin
                                phase_next = PH_DELTA_TWO;
                            end
                            else
                            begin
                                phase_next     = bl_phase;
                                value_rem_next = bl_value;
                            end
                        end
                    end
                    PH_DELTA_TWO:
                    begin
                        phase_next = PH_DELTA_ONE;
                    end
                    PH_DELTA_ONE:
                    begin
                        phase_next     = bl_phase;
                        value_rem_next = bl_value;
                    end
                    PH_LEN_ONE:
                    begin
                        value_rem_next = len_one_value;
                        phase_next     = (len_one_value == '0) ? PH_HEADER : PH_VALUE;
                    end
                    PH_LEN_HI:
                    begin
                        len_hi_next = b;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        value_rem_next = len_two_value;
                        phase_next     = (len_two_value == '0) ? PH_HEADER : PH_VALUE;
                    end
                    PH_VALUE:
                    begin
                        value_rem_next = value_dec;
                        if (value_dec == '0)
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end

            if (!emit && item.last_byte)
            begin
                emit = 1'b1;
                if (phase_next == PH_HEADER)
                begin
                    result.status   = ST_END;
                    result.position = byte_count_next[15:0];
                end
                else
                begin
                    result.status = ST_ERROR;
                end
            end

            if (emit)
            begin
                if (item.last_byte)
                begin
                    phase_next      = PH_HEADER;
                    byte_count_next = '0;
                    value_rem_next  = '0;
                    held_nib_next   = '0;
                    len_hi_next     = '0;
                    decided_next    = 1'b0;
                end
                else
                begin
                    decided_next = 1'b1;
                end
            end
        end

        if (!item_valid)
        begin
            emit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            value_rem_reg  <= '0;
            held_nib_reg   <= '0;
            len_hi_reg     <= '0;
            decided_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            value_rem_reg  <= value_rem_next;
            held_nib_reg   <= held_nib_next;
            len_hi_reg     <= len_hi_next;
            decided_reg    <= decided_next;
        end
    end

    // a decided message gives nothing more until its final byte
    a_quiet_after_decision: assert property (@(posedge clk) disable iff (!rst_n)
        decided_reg && item_valid |-> !emit)
        else $error("result emitted after decision");

    // a result before the final byte parks the parser
    a_decide_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && emit && !item.last_byte |=> decided_reg)
        else $error("parser not parked after result");

    // the final byte always rearms
    a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.last_byte |=>
            phase_reg == PH_HEADER && byte_count_reg == '0 && !decided_reg)
        else $error("parser not rearmed after final byte");

    // a final byte of an undecided message always produces a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item.last_byte && !decided_reg |-> emit)
        else $error("final byte without result");

endmodule

// ----- rtl/core/coap_payload_marker_finder_core.sv -----
// top level of the coap payload marker finder: stream ports and result register
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata[7:0] data_byte, tlast last_byte
//  m_axis    out  m_axis_tvalid/tready    tdata[1:0] status, [17:2] position, [23:18] zero
//
//  one byte per cycle unless a stalled result holds a byte that gives a result; a result is registered
//  after its byte is taken (input register, then parse step into the result register)
//  the parse state is updated from its own registers without a bubble, so bytes follow back to back
//  rst_n clears the parse state and both valid flags; payload registers are not reset
//  a stalled result blocks only bytes that produce a result; others keep flowing
module coap_payload_marker_finder_core
    import cpmf_pkg::*;
#(
    parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [1:0] status, [17:2] position, [23:18] zero
);

    cpmf_item_t   s_item;
    cpmf_item_t   item;
    logic         item_valid;
    logic         advance;
    logic         emit;
    cpmf_result_t result;

    logic         out_valid_reg, out_valid_next;
    cpmf_result_t out_data_reg;

    assign s_item.data_byte = s_axis_tdata;
    assign s_item.last_byte = s_axis_tlast;

    // a byte with no result never waits on the output side
    assign advance = item_valid && (!out_valid_reg || m_axis_tready || !emit);

    cpmf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cpmf_parser #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .step_en    (advance),
        .emit       (emit),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_data_reg.position, out_data_reg.status};

    // an error result always carries position zero
    a_error_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status == ST_ERROR |-> out_data_reg.position == '0)
        else $error("error result with nonzero position");

    // a pending result is never overwritten by a new one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !(advance && emit))
        else $error("pending result overwritten");

endmodule

// ----- verif/tb_coap_payload_marker_finder_core.sv -----
// testbench of the coap payload marker finder core: directed and random message tests
`timescale 1ns / 1ps

module tb_coap_payload_marker_finder_core;
    import cpmf_pkg::*;

    localparam int unsigned MAX_BYTES = MAX_MESSAGE_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_BYTES = 600;
    localparam int PRINT_CAP = 100;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [1:0] status, [17:2] position, [23:18] zero

    coap_payload_marker_finder_core #(
        .MAX_MESSAGE_BYTES(MAX_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // parser state mirrored by the predictor
    logic [PHASE_W-1:0] pr_phase;
    logic [COUNT_W-1:0] pr_count;
    logic [COUNT_W-1:0] pr_remaining;
    logic [3:0]         pr_len_nib;
    logic [7:0]         pr_len_hi;
    bit                 pr_decided;

    cpmf_result_t pending_verdicts[$];
    cpmf_result_t want_verdict;
    logic [7:0]   msg_bytes[$];

    int err_count;
    int bytes_parsed;
    int verdicts_predicted;
    int verdicts_seen;
    int markers_found;
    int clean_ends;
    int errors_flagged;
    int idle_cycles;
    bit tx_idle_en;
    bit rx_idle_en;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function void reset_parser();
        pr_phase     = PH_HEADER;
        pr_count     = '0;
        pr_remaining = '0;
        pr_len_nib   = '0;
        pr_len_hi    = '0;
        pr_decided   = 1'b0;
    endfunction

    function void set_value_len(input logic [COUNT_W-1:0] n);
        pr_remaining = n;
        pr_phase = (n == '0) ? PH_HEADER : PH_VALUE;
    endfunction

    function void begin_length();
        if (pr_len_nib == NIB_EXT_ONE)
            pr_phase = PH_LEN_ONE;
        else if (pr_len_nib == NIB_EXT_TWO)
            pr_phase = PH_LEN_HI;
        else
            set_value_len({13'd0, pr_len_nib});
    endfunction

    // advances the mirrored parser by one byte, returns 1 when a verdict is due
    function automatic bit parse_byte(input logic [7:0] b, input logic l,
                                      output cpmf_result_t res);
        logic [COUNT_W-1:0] offset;
        logic [3:0]         dnib;
        bit                 emit;
        emit = 1'b0;
        res.status = ST_MARKER;
        res.position = '0;
        offset = pr_count;
        if (pr_decided)
        begin
            if (l)
                reset_parser();
            return 1'b0;
        end
        pr_count = pr_count + COUNT_W'(1);
        if (offset >= MAX_BYTES)
        begin
            res.status = ST_ERROR;
            emit = 1'b1;
        end
        else
        begin
            case (pr_phase)
                PH_HEADER:
                begin
                    if (b == MARKER_BYTE)
                    begin
                        res.status = ST_MARKER;
                        res.position = offset[15:0];
                        emit = 1'b1;
                    end
                    else
                    begin
                        dnib = b[7:4];
                        pr_len_nib = b[3:0];
                        if (dnib == NIB_RESERVED || pr_len_nib == NIB_RESERVED)
                        begin
                            res.status = ST_ERROR;
                            emit = 1'b1;
                        end
                        else if (dnib == NIB_EXT_ONE)
                            pr_phase = PH_DELTA_ONE;
                        else if (dnib == NIB_EXT_TWO)
                            pr_phase = PH_DELTA_TWO;
                        else
                            begin_length();
                    end
                end
                PH_DELTA_TWO: pr_phase = PH_DELTA_ONE;
                PH_DELTA_ONE: begin_length();
                PH_LEN_ONE:   set_value_len({9'd0, b} + LEN_ONE_BIAS);
                PH_LEN_HI:
                begin
                    pr_len_hi = b;
                    pr_phase = PH_LEN_LO;
                end
                PH_LEN_LO:    set_value_len({1'b0, pr_len_hi, b} + LEN_TWO_BIAS);
                PH_VALUE:
                begin
                    pr_remaining = pr_remaining - COUNT_W'(1);
                    if (pr_remaining == '0)
                        pr_phase = PH_HEADER;
                end
                default:      pr_phase = PH_HEADER;
            endcase
        end
        // final byte settles the message if nothing was reported yet
        if (!emit && l)
        begin
            emit = 1'b1;
            if (pr_phase == PH_HEADER)
            begin
                res.status = ST_END;
                res.position = pr_count[15:0];
            end
            else
            begin
                res.status = ST_ERROR;
            end
        end
        if (emit)
        begin
            if (l)
                reset_parser();
            else
                pr_decided = 1'b1;
        end
        return emit;
    endfunction

    task report_mismatch(input string what, input int unsigned want, input int unsigned got);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("mismatch at %0t: %s, want %0d got %0d", $realtime, what, want, got);
    endtask

    // drives one byte and waits for its transaction, then records the prediction
    task send_byte(input logic [7:0] b, input logic l);
        int           gap;
        cpmf_result_t res;
        gap = tx_idle_en ? idle_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (!pr_decided)
            bytes_parsed++;
        if (parse_byte(b, l, res))
        begin
            pending_verdicts.push_back(res);
            verdicts_predicted++;
        end
    endtask

    task send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one message per special case, each entry is {last, byte}
    task test_directed();
        logic [8:0] seq[25];
        seq = '{
            {1'b1, 8'hFF},                                  // marker at offset zero
            {1'b1, 8'h00},                                  // empty option, clean end
            {1'b0, 8'h01}, {1'b0, 8'hAA}, {1'b1, 8'hFF},    // marker after a value
            {1'b0, 8'hF0}, {1'b1, 8'h00},                   // delta nibble fifteen
            {1'b1, 8'h0F},                                  // length nibble fifteen
            {1'b1, 8'hD0},                                  // extended delta owed
            {1'b0, 8'h0D}, {1'b1, 8'h00},                   // value bytes owed
            {1'b0, 8'h21}, {1'b1, 8'hFF},                   // 0xff inside a value
            {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b1, 8'h00},    // bytes after marker ignored
            {1'b0, 8'hE1}, {1'b0, 8'h12}, {1'b0, 8'h34}, {1'b1, 8'h56},
            {1'b0, 8'hD2}, {1'b0, 8'h07}, {1'b0, 8'h11}, {1'b0, 8'h22}, {1'b1, 8'hFF}
        };
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        foreach (seq[i])
            send_byte(seq[i][7:0], seq[i][8]);
        wait_idle();
    endtask

    task test_random_messages();
        int         sent;
        int         ending;
        int         nopt;
        int         r;
        logic [3:0] dn;
        logic [3:0] ln;
        int         vlen;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            msg_bytes.delete();
            ending = $urandom_range(0, 99);
            if (ending < 10)
            begin
                // plain noise
                repeat ($urandom_range(1, 6))
                    msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                nopt = (ending < 50) ? $urandom_range(0, 3) : $urandom_range(1, 3);
                repeat (nopt)
                begin
                    dn = 4'($urandom_range(0, 14));
                    r = $urandom_range(0, 99);
                    if (r < 75)
                    begin
                        ln = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 2))
                                                         : 4'($urandom_range(0, 12));
                        vlen = int'(ln);
                    end
                    else if (r < 98)
                    begin
                        ln = NIB_EXT_ONE;
                        vlen = $urandom_range(0, 12);
                    end
                    else
                    begin
                        ln = NIB_EXT_TWO;
                        vlen = $urandom_range(0, 16);
                    end
                    msg_bytes.push_back({dn, ln});
                    if (dn == NIB_EXT_ONE || dn == NIB_EXT_TWO)
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                    if (dn == NIB_EXT_TWO)
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                    if (ln == NIB_EXT_ONE)
                        msg_bytes.push_back(8'(vlen));
                    if (ln == NIB_EXT_TWO)
                    begin
                        msg_bytes.push_back(8'h00);
                        msg_bytes.push_back(8'(vlen));
                        vlen = vlen + 269;
                    end
                    else if (ln == NIB_EXT_ONE)
                    begin
                        vlen = vlen + 13;
                    end
                    repeat (vlen)
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
                if (ending < 50)
                begin
                    msg_bytes.push_back(MARKER_BYTE);
                    repeat ($urandom_range(0, 3))
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else if (ending < 85)
                begin
                    // ends cleanly after the last option
                end
                else if (ending < 93)
                begin
                    // cut the message short somewhere inside
                    repeat ($urandom_range(1, msg_bytes.size() - 1))
                        void'(msg_bytes.pop_back());
                    if (msg_bytes.size() == 0)
                        msg_bytes.push_back(8'hD0);
                end
                else
                begin
                    if ($urandom_range(0, 1) != 0)
                        msg_bytes.push_back({NIB_RESERVED, 4'($urandom_range(0, 14))});
                    else
                        msg_bytes.push_back({4'($urandom_range(0, 14)), NIB_RESERVED});
                    repeat ($urandom_range(0, 2))
                        msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            sent = sent + msg_bytes.size();
            send_message();
        end
        wait_idle();
    endtask

    // result side stalls in bursts
    initial
    begin
        int n;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            n = rx_idle_en ? idle_len() : 0;
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    // compare every result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("result with nothing pending, status", 0, m_axis_tdata[1:0]);
            end
            else
            begin
                want_verdict = pending_verdicts.pop_front();
                case (want_verdict.status)
                    ST_MARKER: markers_found++;
                    ST_END:    clean_ends++;
                    default:   errors_flagged++;
                endcase
                if (m_axis_tdata[1:0] !== want_verdict.status)
                    report_mismatch("status", want_verdict.status, m_axis_tdata[1:0]);
                if (m_axis_tdata[17:2] !== want_verdict.position)
                    report_mismatch("position", want_verdict.position, m_axis_tdata[17:2]);
                if (m_axis_tdata[23:18] !== 6'd0)
                    report_mismatch("padding bits", 0, m_axis_tdata[23:18]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 WATCHDOG_LIMIT, pending_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        err_count = 0;
        bytes_parsed = 0;
        verdicts_predicted = 0;
        verdicts_seen = 0;
        markers_found = 0;
        clean_ends = 0;
        errors_flagged = 0;
        idle_cycles = 0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        reset_parser();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_messages();

        $display("parsed %0d bytes, checked %0d results: %0d markers, %0d clean ends, %0d errors",
                 bytes_parsed, verdicts_seen, markers_found, clean_ends, errors_flagged);
        $display("covered each special case once plus random messages under stalls on both sides");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
